// ----- rtl/glos_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// glos_pkg
// Shared constants, codes and controller/datapath types of the grid
// line-of-sight checker.
// ----------------------------------------------------------------------------
package glos_pkg;

    // Grid storage and coordinate range
    localparam int MAX_CELLS  = 65536;
    localparam int COORD_BITS = 8;
    localparam int ADDR_BITS  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

    // Port field widths
    localparam int FIELD_W     = 8;
    localparam int DIM_W       = 9;
    localparam int NEUTRAL_W   = 8;
    localparam int FACTOR_W    = 10;
    localparam int THR_W       = 9;
    localparam int COST_W      = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    // Internal widths
    localparam int SC_W       = COORD_BITS + 2;      // signed probe coordinate
    localparam int ROW_W      = SC_W + DIM_W + 1;    // signed row offset y * width
    localparam int IDX_W      = ROW_W + 1;           // signed linear index
    localparam int CELLS_W    = 2 * DIM_W;
    localparam int F_W        = COORD_BITS + 1;      // walk error term
    localparam int FPROD_W    = FACTOR_W + FIELD_W;
    localparam int FSUM_W     = FPROD_W - 8 + 1;

    // Stored cost codes
    localparam logic [COST_W-1:0] COST_FREE_MAX = 8'd253;
    localparam logic [COST_W-1:0] COST_FORBID   = 8'd254;
    localparam logic [COST_W-1:0] COST_UNK      = 8'd255;

    // Register reset values
    localparam logic [DIM_W-1:0]     RST_GRID_WIDTH      = 9'd256;
    localparam logic [DIM_W-1:0]     RST_GRID_HEIGHT     = 9'd256;
    localparam logic [NEUTRAL_W-1:0] RST_NEUTRAL_COST    = 8'd1;
    localparam logic [FACTOR_W-1:0]  RST_COST_FACTOR     = 10'd205;
    localparam logic                 RST_ALLOW_UNKNOWN   = 1'b1;
    localparam logic [THR_W-1:0]     RST_CHEAP_THRESHOLD = 9'd150;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GRID_WIDTH,
        REG_GRID_HEIGHT,
        REG_NEUTRAL_COST,
        REG_COST_FACTOR,
        REG_ALLOW_UNKNOWN,
        REG_CHEAP_THRESHOLD
    } glos_reg_t;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_STEP,
        ST_CHECK,
        ST_AFTER_A,
        ST_ADDR,
        ST_IDX,
        ST_READ,
        ST_EVAL,
        ST_LOAD_WR,
        ST_FINISH
    } glos_state_t;

    // Which cell a probe looks at
    typedef enum logic [2:0] {
        PH_LOAD,    // loaded cell
        PH_A,       // diagonal cell before the minor step
        PH_B,       // diagonal cell after the minor step
        PH_C0,      // side cell of an axis-aligned line
        PH_C1       // other side cell of an axis-aligned line
    } glos_phase_t;

    typedef struct packed {
        logic        capture;
        logic        setup;
        logic        f_add;
        logic        minor_step;
        logic        major_step;
        logic        probe_addr;
        logic        probe_idx;
        glos_phase_t phase;
        logic        ram_rd;
        logic        ram_wr;
        logic        res_load;
        logic        res_val;
    } glos_cmd_t;

    typedef struct packed {
        logic maj_done;
        logic f_ge;
        logic f_nz;
        logic dmin_zero;
        logic cheap;
    } glos_stat_t;

endpackage
`default_nettype wire

// ----- rtl/glos_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// glos_in_if / glos_out_if
// Valid/ready channels of the line-of-sight checker: request items in,
// visibility results out.
// ----------------------------------------------------------------------------
interface glos_in_if import glos_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               func;
    logic [FIELD_W-1:0] from_x;
    logic [FIELD_W-1:0] from_y;
    logic [FIELD_W-1:0] to_x;
    logic [FIELD_W-1:0] to_y;
    logic [FIELD_W-1:0] raw_cost;

    modport source (
        output valid, func, from_x, from_y, to_x, to_y, raw_cost,
        input  ready
    );
    modport sink (
        input  valid, func, from_x, from_y, to_x, to_y, raw_cost,
        output ready
    );
endinterface

interface glos_out_if ();
    logic valid;
    logic ready;
    logic visible;

    modport source (
        output valid, visible,
        input  ready
    );
    modport sink (
        input  valid, visible,
        output ready
    );
endinterface
`default_nettype wire

// ----- rtl/glos_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// glos_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module glos_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/glos_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// glos_dp
// Datapath: configuration registers, Bresenham walk registers, cell probe
// pipeline (row multiply, index and range check, memory read) and cost
// conversion for loads.
// ----------------------------------------------------------------------------
module glos_dp import glos_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [FIELD_W-1:0]     from_x,
    input  logic [FIELD_W-1:0]     from_y,
    input  logic [FIELD_W-1:0]     to_x,
    input  logic [FIELD_W-1:0]     to_y,
    input  logic [FIELD_W-1:0]     raw_cost,
    input  glos_cmd_t              cmd,
    output glos_stat_t             stat,
    output logic                   visible
);

    // Configuration
    logic [DIM_W-1:0]     grid_width_reg;
    logic [DIM_W-1:0]     grid_height_reg;
    logic [NEUTRAL_W-1:0] neutral_cost_reg;
    logic [FACTOR_W-1:0]  cost_factor_reg;
    logic                 allow_unknown_reg;
    logic [THR_W-1:0]     cheap_threshold_reg;

    // Captured item
    logic [COORD_BITS-1:0] fx_reg, fy_reg, tx_reg, ty_reg;
    logic [FIELD_W-1:0]    raw_reg;

    // Walk state, major/minor axis form
    logic                  xmaj_reg;
    logic [COORD_BITS-1:0] maj_reg, mn_reg, maj_end_reg;
    logic [COORD_BITS-1:0] dmaj_reg, dmin_reg;
    logic                  smaj_neg_reg, smin_neg_reg;
    logic [F_W-1:0]        f_reg;
    logic [CELLS_W-1:0]    cells_reg;

    // Probe pipeline
    logic signed [SC_W-1:0]  px_reg;
    logic signed [ROW_W-1:0] rowp_reg;
    logic [FPROD_W-1:0]      fprod_reg;
    logic                    in_ok_reg;
    logic                    ok_reg;
    logic                    load_ok_reg;
    logic [ADDR_BITS-1:0]    addr_reg;
    logic [COST_W-1:0]       wdata_reg;
    logic                    visible_reg;

    logic [COST_W-1:0] rd_data;

    // Setup terms
    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS-1:0]      adx, ady;
    logic                       x_major;

    // Probe terms
    logic [SC_W-1:0]          pa, pb, px_u, py_u;
    logic signed [DIM_W:0]    width_s;
    logic signed [IDX_W-1:0]  idx;
    logic [31:0]              idx_mag;
    logic                     below_max;
    logic                     in_cells;
    logic [FSUM_W-1:0]        fsum;
    logic [COST_W-1:0]        free_cost;
    logic [COST_W-1:0]        conv_cost;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg      <= RST_GRID_WIDTH;
            grid_height_reg     <= RST_GRID_HEIGHT;
            neutral_cost_reg    <= RST_NEUTRAL_COST;
            cost_factor_reg     <= RST_COST_FACTOR;
            allow_unknown_reg   <= RST_ALLOW_UNKNOWN;
            cheap_threshold_reg <= RST_CHEAP_THRESHOLD;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:      grid_width_reg      <= cfg_data[DIM_W-1:0];
                REG_GRID_HEIGHT:     grid_height_reg     <= cfg_data[DIM_W-1:0];
                REG_NEUTRAL_COST:    neutral_cost_reg    <= cfg_data[NEUTRAL_W-1:0];
                REG_COST_FACTOR:     cost_factor_reg     <= cfg_data[FACTOR_W-1:0];
                REG_ALLOW_UNKNOWN:   allow_unknown_reg   <= cfg_data[0];
                REG_CHEAP_THRESHOLD: cheap_threshold_reg <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        dx      = $signed({1'b0, tx_reg}) - $signed({1'b0, fx_reg});
        dy      = $signed({1'b0, ty_reg}) - $signed({1'b0, fy_reg});
        adx     = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
        ady     = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
        x_major = (adx >= ady);
    end

    // Probe cell: load cell, or walk position offset toward travel direction
    always_comb
    begin
        pa = SC_W'(maj_reg) - SC_W'(smaj_neg_reg);
        case (cmd.phase)
            PH_C0:   pb = SC_W'(mn_reg);
            PH_C1:   pb = SC_W'(mn_reg) - SC_W'(1'b1);
            default: pb = SC_W'(mn_reg) - SC_W'(smin_neg_reg);
        endcase
        if (cmd.phase == PH_LOAD)
        begin
            px_u = SC_W'(fx_reg);
            py_u = SC_W'(fy_reg);
        end
        else if (xmaj_reg)
        begin
            px_u = pa;
            py_u = pb;
        end
        else
        begin
            px_u = pb;
            py_u = pa;
        end
        width_s = $signed({1'b0, grid_width_reg});
    end

    always_comb
    begin
        idx       = IDX_W'(px_reg) + IDX_W'(rowp_reg);
        idx_mag   = 32'($unsigned(idx));
        below_max = (idx_mag < 32'(MAX_CELLS));
        in_cells  = (idx_mag < 32'(cells_reg));
    end

    // Cost conversion
    always_comb
    begin
        fsum = FSUM_W'(neutral_cost_reg) + FSUM_W'(fprod_reg[FPROD_W-1:8]);
        free_cost = (fsum >= FSUM_W'(COST_FORBID)) ? COST_FREE_MAX : COST_W'(fsum);
        if (raw_reg < COST_FREE_MAX)
        begin
            conv_cost = free_cost;
        end
        else if (raw_reg == COST_UNK && allow_unknown_reg)
        begin
            conv_cost = COST_UNK;
        end
        else
        begin
            conv_cost = COST_FORBID;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            fx_reg  <= COORD_BITS'(from_x);
            fy_reg  <= COORD_BITS'(from_y);
            tx_reg  <= COORD_BITS'(to_x);
            ty_reg  <= COORD_BITS'(to_y);
            raw_reg <= raw_cost;
        end

        if (cmd.setup)
        begin
            xmaj_reg     <= x_major;
            maj_reg      <= x_major ? fx_reg : fy_reg;
            mn_reg       <= x_major ? fy_reg : fx_reg;
            maj_end_reg  <= x_major ? tx_reg : ty_reg;
            dmaj_reg     <= x_major ? adx : ady;
            dmin_reg     <= x_major ? ady : adx;
            smaj_neg_reg <= x_major ? dx[COORD_BITS] : dy[COORD_BITS];
            smin_neg_reg <= x_major ? dy[COORD_BITS] : dx[COORD_BITS];
            cells_reg    <= CELLS_W'(grid_width_reg) * CELLS_W'(grid_height_reg);
        end

        if (cmd.setup)
        begin
            f_reg <= '0;
        end
        else if (cmd.f_add)
        begin
            f_reg <= f_reg + F_W'(dmin_reg);
        end
        else if (cmd.minor_step)
        begin
            f_reg <= f_reg - F_W'(dmaj_reg);
        end

        if (cmd.minor_step)
        begin
            mn_reg <= smin_neg_reg ? mn_reg - 1'b1 : mn_reg + 1'b1;
        end
        if (cmd.major_step)
        begin
            maj_reg <= smaj_neg_reg ? maj_reg - 1'b1 : maj_reg + 1'b1;
        end

        // Stage one: row offset, cost scale and load range check
        if (cmd.probe_addr)
        begin
            px_reg    <= $signed(px_u);
            rowp_reg  <= $signed(py_u) * width_s;
            fprod_reg <= FPROD_W'(cost_factor_reg) * FPROD_W'(raw_reg);
            in_ok_reg <= (32'(fx_reg) < 32'(grid_width_reg))
                         && (32'(fy_reg) < 32'(grid_height_reg));
        end

        // Stage two: linear index, range checks and cost conversion
        if (cmd.probe_idx)
        begin
            ok_reg      <= !idx[IDX_W-1] && in_cells && below_max;
            load_ok_reg <= in_ok_reg && below_max;
            addr_reg    <= ADDR_BITS'($unsigned(idx));
            wdata_reg   <= conv_cost;
        end

        if (cmd.res_load)
        begin
            visible_reg <= cmd.res_val;
        end
    end

    glos_ram #(
        .WIDTH (COST_W),
        .DEPTH (MAX_CELLS)
    ) u_grid (
        .clk     (clk),
        .wr_en   (cmd.ram_wr && load_ok_reg),
        .wr_addr (addr_reg),
        .wr_data (wdata_reg),
        .rd_en   (cmd.ram_rd),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        stat.maj_done  = (maj_reg == maj_end_reg);
        stat.f_ge      = (f_reg >= F_W'(dmaj_reg));
        stat.f_nz      = (f_reg != '0);
        stat.dmin_zero = (dmin_reg == '0);
        stat.cheap     = ok_reg && ({1'b0, rd_data} < cheap_threshold_reg);
    end

    assign visible = visible_reg;

endmodule
`default_nettype wire

// ----- rtl/glos_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// glos_ctrl
// Controller: sequences cell loads and the line walk, drives one probe at a
// time through the datapath and holds the result item for the output side.
// ----------------------------------------------------------------------------
module glos_ctrl import glos_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_func,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  glos_stat_t stat,
    output glos_cmd_t  cmd
);

    glos_state_t state_reg, state_next;
    glos_phase_t phase_reg, phase_next;
    logic        vis_reg, vis_next;
    logic        out_valid_reg, out_valid_next;
    logic        res_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_LOAD;
            vis_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            vis_reg       <= vis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign res_take = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        vis_next   = vis_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_func == FUNC_QUERY)
                    begin
                        state_next = ST_SETUP;
                    end
                    else
                    begin
                        phase_next = PH_LOAD;
                        state_next = ST_ADDR;
                    end
                end
            end
            ST_SETUP:
            begin
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (stat.maj_done)
                begin
                    vis_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.f_ge)
                begin
                    phase_next = PH_A;
                    state_next = ST_ADDR;
                end
                else
                begin
                    state_next = ST_AFTER_A;
                end
            end
            ST_AFTER_A:
            begin
                if (stat.f_nz)
                begin
                    phase_next = PH_B;
                    state_next = ST_ADDR;
                end
                else if (stat.dmin_zero)
                begin
                    phase_next = PH_C0;
                    state_next = ST_ADDR;
                end
                else
                begin
                    state_next = ST_STEP;
                end
            end
            ST_ADDR:
            begin
                state_next = ST_IDX;
            end
            ST_IDX:
            begin
                state_next = (phase_reg == PH_LOAD) ? ST_LOAD_WR : ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (stat.cheap)
                begin
                    state_next = (phase_reg == PH_A) ? ST_AFTER_A : ST_STEP;
                end
                else if (phase_reg == PH_C0)
                begin
                    // one side blocked: try the other side
                    phase_next = PH_C1;
                    state_next = ST_ADDR;
                end
                else
                begin
                    vis_next   = 1'b0;
                    state_next = ST_FINISH;
                end
            end
            ST_LOAD_WR:
            begin
                state_next = ST_IDLE;
            end
            ST_FINISH:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Outputs
    always_comb
    begin
        cmd          = '0;
        cmd.phase    = phase_reg;
        cmd.res_val  = vis_reg;
        in_ready     = (state_reg == ST_IDLE);
        cmd.capture  = in_valid && (state_reg == ST_IDLE);
        case (state_reg)
            ST_SETUP:   cmd.setup      = 1'b1;
            ST_STEP:    cmd.f_add      = !stat.maj_done;
            ST_AFTER_A: cmd.major_step = !stat.f_nz && !stat.dmin_zero;
            ST_ADDR:    cmd.probe_addr = 1'b1;
            ST_IDX:     cmd.probe_idx  = 1'b1;
            ST_READ:    cmd.ram_rd     = 1'b1;
            ST_EVAL:
            begin
                cmd.minor_step = stat.cheap && (phase_reg == PH_A);
                cmd.major_step = stat.cheap && (phase_reg != PH_A);
            end
            ST_LOAD_WR: cmd.ram_wr     = 1'b1;
            ST_FINISH:  cmd.res_load   = res_take;
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_read_not_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (phase_reg != PH_LOAD))
        else $error("cell read issued for a load item");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finish state");

    a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_valid_reg && !out_ready)
        |=> (state_reg == ST_FINISH && out_valid_reg))
        else $error("pending result overwritten while output stalled");
`endif

endmodule
`default_nettype wire

// ----- rtl/grid_line_of_sight_checker_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// grid_line_of_sight_checker_core
// Cost grid with cell loads and Theta*-style line-of-sight queries.
// ----------------------------------------------------------------------------
// Items are handled one at a time. A load passes the row multiply, the index
// and range check and the memory write after acceptance. A query runs setup
// and then, for each step along the major axis, walk control and the cell
// probes (row multiply, index and range check, grid memory read, compare); a
// step probes at most two cells, and every probe goes through the single read
// port of the cost memory. The result item sits in an output register, so the
// next request is taken while it waits. The cost memory is not cleared after
// reset: every cell a query touches must have been loaded first.
// ----------------------------------------------------------------------------
module grid_line_of_sight_checker_core import glos_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    glos_in_if.sink                req,
    glos_out_if.source             rsp,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    glos_cmd_t  dp_cmd;
    glos_stat_t dp_stat;

    glos_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_func   (req.func),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    glos_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .from_x    (req.from_x),
        .from_y    (req.from_y),
        .to_x      (req.to_x),
        .to_y      (req.to_y),
        .raw_cost  (req.raw_cost),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .visible   (rsp.visible)
    );

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the grid line-of-sight checker. A behavioral copy
// of the cost grid and the sight walk predicts every query result; results
// are matched in order while both channels idle and stall at random across
// a range of grid shapes and cost settings.
// ----------------------------------------------------------------------------
module tb import glos_pkg::*; ();

    localparam int STALL_LIMIT   = 20000;  // cycles without any handshake
    localparam int SETTLE_CYCLES = 16;     // a load still in flight finishes here

    typedef struct {
        logic               func;
        logic [FIELD_W-1:0] from_x;
        logic [FIELD_W-1:0] from_y;
        logic [FIELD_W-1:0] to_x;
        logic [FIELD_W-1:0] to_y;
        logic [FIELD_W-1:0] raw_cost;
    } glos_item_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    glos_in_if  req_ch ();
    glos_out_if rsp_ch ();

    grid_line_of_sight_checker_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the block's registers and cost memory
    logic [DIM_W-1:0]     cfg_width;
    logic [DIM_W-1:0]     cfg_height;
    logic [NEUTRAL_W-1:0] cfg_neutral;
    logic [FACTOR_W-1:0]  cfg_factor;
    logic                 cfg_unknown;
    logic [THR_W-1:0]     cfg_threshold;
    logic [COST_W-1:0]    cost_mem [MAX_CELLS];
    bit                   cell_written [MAX_CELLS];
    bit                   unloaded_hit;

    bit          visible_q [$];
    int unsigned err_count;
    int unsigned stall_cycles;
    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    int unsigned phase_count;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic [COST_W-1:0] stored_cost(logic [FIELD_W-1:0] raw);
        int sum;
        if (raw < COST_FREE_MAX)
        begin
            sum = int'(cfg_neutral) + ((int'(cfg_factor) * int'(raw)) >> 8);
            return (sum >= int'(COST_FORBID)) ? COST_FREE_MAX : COST_W'(sum);
        end
        if (raw == COST_UNK && cfg_unknown)
            return COST_UNK;
        return COST_FORBID;
    endfunction

    // In audit mode every probe passes, and in-range cells never loaded are flagged.
    function automatic bit cell_passable(int mx, int my, bit audit);
        longint idx;
        idx = longint'(mx) + longint'(my) * longint'(cfg_width);
        if (idx < 0 || idx >= longint'(cfg_width) * longint'(cfg_height) || idx >= MAX_CELLS)
            return audit;
        if (audit)
        begin
            if (!cell_written[idx])
                unloaded_hit = 1'b1;
            return 1'b1;
        end
        return cost_mem[idx] < cfg_threshold;
    endfunction

    function automatic bit sight_clear(int x0, int y0, int x1, int y1, bit audit);
        int dx;
        int dy;
        int f;
        int sx;
        int sy;
        int ox;
        int oy;
        bit side0;
        bit side1;
        dx = x1 - x0;
        dy = y1 - y0;
        f  = 0;
        sx = 1;
        sy = 1;
        if (dy < 0)
        begin
            dy = -dy;
            sy = -1;
        end
        if (dx < 0)
        begin
            dx = -dx;
            sx = -1;
        end
        ox = (sx < 0) ? -1 : 0;
        oy = (sy < 0) ? -1 : 0;
        if (dx >= dy)
        begin
            while (x0 != x1)
            begin
                f += dy;
                if (f >= dx)
                begin
                    if (!cell_passable(x0 + ox, y0 + oy, audit))
                        return 1'b0;
                    y0 += sy;
                    f  -= dx;
                end
                if (f != 0 && !cell_passable(x0 + ox, y0 + oy, audit))
                    return 1'b0;
                // axis-aligned: blocked only when both side cells are expensive
                if (dy == 0)
                begin
                    side0 = cell_passable(x0 + ox, y0, audit);
                    side1 = cell_passable(x0 + ox, y0 - 1, audit);
                    if (!side0 && !side1)
                        return 1'b0;
                end
                x0 += sx;
            end
        end
        else
        begin
            while (y0 != y1)
            begin
                f += dx;
                if (f >= dy)
                begin
                    if (!cell_passable(x0 + ox, y0 + oy, audit))
                        return 1'b0;
                    x0 += sx;
                    f  -= dy;
                end
                if (f != 0 && !cell_passable(x0 + ox, y0 + oy, audit))
                    return 1'b0;
                if (dx == 0)
                begin
                    side0 = cell_passable(x0, y0 + oy, audit);
                    side1 = cell_passable(x0 - 1, y0 + oy, audit);
                    if (!side0 && !side1)
                        return 1'b0;
                end
                y0 += sy;
            end
        end
        return 1'b1;
    endfunction

    function automatic bit query_reads_loaded(glos_item_t it);
        unloaded_hit = 1'b0;
        void'(sight_clear(it.from_x, it.from_y, it.to_x, it.to_y, 1'b1));
        return !unloaded_hit;
    endfunction

    function automatic void track_item(glos_item_t it);
        longint idx;
        if (it.func == FUNC_LOAD)
        begin
            idx = longint'(it.from_x) + longint'(it.from_y) * longint'(cfg_width);
            if (it.from_x < cfg_width && it.from_y < cfg_height && idx < MAX_CELLS)
            begin
                cost_mem[idx]     = stored_cost(it.raw_cost);
                cell_written[idx] = 1'b1;
            end
        end
        else
        begin
            visible_q.insert(visible_q.size(),
                             sight_clear(it.from_x, it.from_y, it.to_x, it.to_y, 1'b0));
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking, receiver stalls and watchdog
    // ------------------------------------------------------------------
    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (visible_q.size() == 0)
            begin
                if (err_count < 10)
                    $display("%0t: result visible=%0b with no query pending",
                             $realtime, rsp_ch.visible);
                err_count++;
            end
            else if (rsp_ch.visible !== visible_q[0])
            begin
                if (err_count < 10)
                    $display("%0t: visible mismatch: expected %0b, got %0b",
                             $realtime, visible_q[0], rsp_ch.visible);
                err_count++;
                void'(visible_q.pop_front());
            end
            else
            begin
                void'(visible_q.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    task automatic send_item(glos_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.func     <= it.func;
        req_ch.from_x   <= it.from_x;
        req_ch.from_y   <= it.from_y;
        req_ch.to_x     <= it.to_x;
        req_ch.to_y     <= it.to_y;
        req_ch.raw_cost <= it.raw_cost;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        track_item(it);
    endtask

    task automatic send_load(int x, int y, int raw);
        glos_item_t it;
        it.func     = FUNC_LOAD;
        it.from_x   = FIELD_W'(x);
        it.from_y   = FIELD_W'(y);
        it.to_x     = FIELD_W'($urandom());
        it.to_y     = FIELD_W'($urandom());
        it.raw_cost = FIELD_W'(raw);
        send_item(it);
    endtask

    task automatic send_query(int x0, int y0, int x1, int y1);
        glos_item_t it;
        it.func     = FUNC_QUERY;
        it.from_x   = FIELD_W'(x0);
        it.from_y   = FIELD_W'(y0);
        it.to_x     = FIELD_W'(x1);
        it.to_y     = FIELD_W'(y1);
        it.raw_cost = FIELD_W'($urandom());
        send_item(it);
    endtask

    // Drop valid and wait until every query has answered and a load has settled.
    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (visible_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(glos_reg_t r, int unsigned value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= r;
        cfg_data  <= CFG_DATA_W'(value);
        case (r)
            REG_GRID_WIDTH:      cfg_width     = DIM_W'(value);
            REG_GRID_HEIGHT:     cfg_height    = DIM_W'(value);
            REG_NEUTRAL_COST:    cfg_neutral   = NEUTRAL_W'(value);
            REG_COST_FACTOR:     cfg_factor    = FACTOR_W'(value);
            REG_ALLOW_UNKNOWN:   cfg_unknown   = value[0];
            REG_CHEAP_THRESHOLD: cfg_threshold = THR_W'(value);
            default: ;
        endcase
    endtask

    task automatic set_config(int unsigned w, int unsigned h, int unsigned neutral,
                              int unsigned factor, int unsigned unknown,
                              int unsigned threshold);
        drain();
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        write_reg(REG_NEUTRAL_COST, neutral);
        write_reg(REG_COST_FACTOR, factor);
        write_reg(REG_ALLOW_UNKNOWN, unknown);
        write_reg(REG_CHEAP_THRESHOLD, threshold);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        // rotate the idle pattern from one phase to the next
        case (phase_count % 4)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 60; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 60; end
            default: begin src_idle_pct = 31; snk_stall_pct = 31; end
        endcase
        phase_count++;
    endtask

    function automatic int pick_raw(int obst_pct);
        if ($urandom_range(99) < obst_pct)
            return $urandom_range(255, 151);
        return $urandom_range(150, 0);
    endfunction

    function automatic logic [FIELD_W-1:0] pick_coord(int unsigned dim);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 6 || dim == 0)
            return FIELD_W'($urandom_range(255));
        if (roll < 20)
            return FIELD_W'($urandom_range((dim > 254) ? 255 : dim + 1));
        return FIELD_W'($urandom_range(((dim > 256) ? 256 : dim) - 1));
    endfunction

    // Load every cell of the current grid with coordinates below 256 that has no cost yet.
    task automatic load_missing_cells(int obst_pct);
        int ncells;
        int idx;
        ncells = int'(cfg_width) * int'(cfg_height);
        for (idx = 0; idx < ncells; idx++)
        begin
            if (!cell_written[idx] && idx % cfg_width < 256 && idx / cfg_width < 256)
                send_load(idx % cfg_width, idx / cfg_width, pick_raw(obst_pct));
        end
    endtask

    task automatic send_random_items(int count, int obst_pct);
        glos_item_t it;
        int         n;
        int         tries;
        for (n = 0; n < count; n++)
        begin
            it.func     = ($urandom_range(99) < 35) ? FUNC_LOAD : FUNC_QUERY;
            it.raw_cost = FIELD_W'(pick_raw(obst_pct));
            tries       = 0;
            do
            begin
                it.from_x = pick_coord(cfg_width);
                it.from_y = pick_coord(cfg_height);
                it.to_x   = pick_coord(cfg_width);
                it.to_y   = pick_coord(cfg_height);
                tries++;
            end
            while (it.func == FUNC_QUERY && !query_reads_loaded(it) && tries < 20);
            // fall back to a zero-length query, which reads nothing
            if (it.func == FUNC_QUERY && !query_reads_loaded(it))
            begin
                it.to_x = it.from_x;
                it.to_y = it.from_y;
            end
            send_item(it);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_corners();
        send_load(0, 0, 0);
        send_load(1, 0, 252);
        send_load(0, 1, 253);
        send_load(1, 1, 254);
        send_load(255, 255, 255);
        send_load(254, 254, 100);
        send_load(255, 0, 0);
        send_load(254, 255, 10);
        send_load(255, 254, 20);
        send_query(0, 0, 1, 1);
        send_query(1, 1, 0, 0);
        send_query(255, 255, 254, 254);
        send_query(254, 254, 255, 255);
        send_query(0, 1, 0, 0);
        send_query(0, 0, 1, 0);
        send_query(1, 0, 2, 0);
        // column -1 aliases to the last cell of the row above
        send_query(0, 1, 0, 2);
        send_query(3, 3, 3, 3);
        send_query(255, 255, 255, 255);
    endtask

    task automatic test_single_row();
        set_config(256, 1, 1, 205, 1, 150);
        load_missing_cells(2);
        send_random_items(110, 2);
    endtask

    task automatic test_cost_extremes();
        set_config(16, 16, 0, 0, 0, 1);
        send_random_items(30, 15);
        set_config(16, 16, 253, 1023, 1, 254);
        send_random_items(30, 15);
        set_config(16, 16, 255, 1023, 0, 256);
        send_random_items(30, 15);
        set_config(16, 16, 0, 512, 1, 0);
        send_random_items(30, 15);
        set_config(16, 16, 10, 300, 1, 511);
        send_random_items(30, 15);
        set_config(16, 16, 1, 205, 0, 150);
        send_random_items(30, 15);
    endtask

    task automatic test_grid_shapes();
        set_config(7, 9, 1, 205, 1, 150);
        load_missing_cells(10);
        // loads past the last column and row are dropped
        send_load(7, 0, 254);
        send_load(0, 9, 254);
        send_random_items(20, 10);
        set_config(1, 64, 1, 205, 1, 150);
        send_random_items(20, 10);
        set_config(64, 4, 0, 100, 0, 120);
        send_random_items(20, 10);
        set_config(0, 5, 1, 205, 1, 150);
        send_random_items(20, 10);
        set_config(300, 1, 1, 205, 1, 150);
        send_random_items(20, 10);
        set_config(5, 0, 1, 205, 1, 150);
        send_random_items(20, 10);
        set_config(1, 511, 2, 400, 1, 200);
        send_random_items(20, 10);
    endtask

    task automatic test_mixed_traffic();
        set_config(8, 8, 1, 205, 1, 150);
        send_random_items(80, 8);
        set_config(12, 12, 5, 150, 0, 180);
        send_random_items(80, 8);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = REG_GRID_WIDTH;
        cfg_data        = '0;
        req_ch.valid    = 1'b0;
        req_ch.func     = FUNC_LOAD;
        req_ch.from_x   = '0;
        req_ch.from_y   = '0;
        req_ch.to_x     = '0;
        req_ch.to_y     = '0;
        req_ch.raw_cost = '0;
        cfg_width       = RST_GRID_WIDTH;
        cfg_height      = RST_GRID_HEIGHT;
        cfg_neutral     = RST_NEUTRAL_COST;
        cfg_factor      = RST_COST_FACTOR;
        cfg_unknown     = RST_ALLOW_UNKNOWN;
        cfg_threshold   = RST_CHEAP_THRESHOLD;
        src_idle_pct    = 0;
        snk_stall_pct   = 0;
        phase_count     = 1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_corners();
        test_single_row();
        test_cost_extremes();
        test_grid_shapes();
        test_mixed_traffic();

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0 && visible_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
